@@ design/kvrp_pkg.sv @@
// Package for the key/value response parser: shared constants, result types
// and the table of expected keys. It depends on nothing else.
`timescale 1ns / 1ps

package kvrp_pkg;

    localparam int MAX_MESSAGE_BYTES = 31;
    localparam int MSG_CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int OUT_TDATA_W = 80;
    localparam int OUT_FIELD_W = 74;

    localparam logic KIND_MESSAGE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  msg_byte;
        logic [31:0] req_ident;
        logic [31:0] status_val;
        logic        outcome;
        logic        truncated;
        logic        is_last;
    } res_t;

    // Up to two results leave the parser for one input transfer.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic [3:0] key_len(logic [1:0] k);
        logic [3:0] len;
        begin
            case (k)
                2'd0:    len = 4'd13;
                2'd1:    len = 4'd10;
                2'd2:    len = 4'd11;
                default: len = 4'd5;
            endcase
            return len;
        end
    endfunction

    // Character at position pos of expected key k; valid while pos < key_len(k).
    function automatic logic [7:0] key_byte(logic [1:0] k, logic [3:0] pos);
        logic [127:0] txt;
        logic [3:0]   idx;
        begin
            case (k)
                2'd0:    txt = 128'("user protocol");
                2'd1:    txt = 128'("request_id");
                2'd2:    txt = 128'("status_code");
                default: txt = 128'("value");
            endcase
            idx = key_len(k) - pos - 4'd1;
            return txt[{idx, 3'b000} +: 8];
        end
    endfunction

endpackage

@@ design/kvrp_parser.sv @@
// Line and key checker with decimal accumulation for the response parser.
// Depends on kvrp_pkg; feeds its results to kvrp_out_fifo.
`timescale 1ns / 1ps

module kvrp_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            end_of_response,
    output kvrp_pkg::push_t push
);
    import kvrp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_STATUS,
        PH_VALUE,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        LP_START,
        LP_KEY,
        LP_SPACES,
        LP_VALUE
    } lpart_t;

    typedef struct packed {
        phase_t                 phase;
        lpart_t                 lp;
        logic [3:0]             kpos;
        logic                   kmis;
        logic [31:0]            acc;
        logic                   started;
        logic                   neg;
        logic                   stopped;
        logic [31:0]            rid;
        logic [31:0]            st;
        logic [MSG_CNT_W-1:0]   mcount;
        logic                   trunc;
    } prs_state_t;

    typedef struct packed {
        prs_state_t s;
        logic       sum;
    } le_t;

    typedef struct packed {
        prs_state_t s;
        logic       msg;
    } vc_t;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    prs_state_t state_reg;
    prs_state_t state_next;

    function automatic prs_state_t init_state();
        prs_state_t s;
        begin
            s = '0;
            s.phase = PH_HEADER;
            s.lp = LP_START;
            return s;
        end
    endfunction

    function automatic prs_state_t clear_line(prs_state_t s);
        prs_state_t r;
        begin
            r = s;
            r.lp = LP_START;
            r.kpos = 4'd0;
            r.kmis = 1'b0;
            r.acc = 32'd0;
            r.started = 1'b0;
            r.neg = 1'b0;
            r.stopped = 1'b0;
            return r;
        end
    endfunction

    function automatic logic active(phase_t p);
        return (p == PH_HEADER) || (p == PH_ID) || (p == PH_STATUS) || (p == PH_VALUE);
    endfunction

    function automatic logic key_done(prs_state_t s);
        return !s.kmis && (s.kpos == key_len(2'(s.phase)));
    endfunction

    function automatic prs_state_t key_char(prs_state_t s, logic [7:0] c);
        prs_state_t r;
        logic [1:0] k;
        begin
            r = s;
            k = 2'(s.phase);
            if ((s.kpos < key_len(k)) && (key_byte(k, s.kpos) == c)) begin
                r.kpos = s.kpos + 4'd1;
            end else begin
                r.kmis = 1'b1;
            end
            return r;
        end
    endfunction

    function automatic vc_t value_char(prs_state_t s, logic [7:0] c);
        vc_t  r;
        logic digit;
        logic [31:0] d;
        begin
            r.s = s;
            r.msg = 1'b0;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            d = {24'd0, c - CH_ZERO};
            if ((s.phase == PH_ID) || (s.phase == PH_STATUS)) begin
                if (!s.stopped) begin
                    if (!s.started) begin
                        if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF)) begin
                            r.s = s;
                        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                            r.s.started = 1'b1;
                            r.s.neg = (c == CH_MINUS);
                        end else if (digit) begin
                            r.s.started = 1'b1;
                            r.s.acc = d;
                        end else begin
                            r.s.stopped = 1'b1;
                        end
                    end else if (digit) begin
                        r.s.acc = (s.acc << 3) + (s.acc << 1) + d;
                    end else begin
                        r.s.stopped = 1'b1;
                    end
                end
            end else if ((s.phase == PH_VALUE) && !s.kmis) begin
                if (s.mcount < MSG_CNT_W'(MAX_MESSAGE_BYTES)) begin
                    r.s.mcount = s.mcount + MSG_CNT_W'(1);
                    r.msg = 1'b1;
                end else begin
                    r.s.trunc = 1'b1;
                end
            end
            return r;
        end
    endfunction

    function automatic le_t line_end(prs_state_t s);
        le_t  r;
        logic match;
        logic [31:0] num;
        begin
            r.s = s;
            r.sum = 1'b0;
            if ((s.lp == LP_START) && !s.kmis) begin
                r.s = clear_line(s);
            end else begin
                if (s.lp == LP_START) begin
                    match = 1'b0;
                end else if (s.lp == LP_KEY) begin
                    match = key_done(s);
                end else begin
                    match = !s.kmis;
                end
                num = s.neg ? (32'd0 - s.acc) : s.acc;
                if (!match) begin
                    r.s.phase = PH_ERROR;
                end else begin
                    case (s.phase)
                        PH_HEADER: r.s.phase = PH_ID;
                        PH_ID:
                        begin
                            r.s.rid = num;
                            r.s.phase = PH_STATUS;
                        end
                        PH_STATUS:
                        begin
                            r.s.st = num;
                            r.s.phase = PH_VALUE;
                        end
                        default:
                        begin
                            r.s.phase = PH_DONE;
                            r.sum = 1'b1;
                        end
                    endcase
                end
                r.s = clear_line(r.s);
            end
            return r;
        end
    endfunction

    always_comb begin
        prs_state_t s;
        le_t        le;
        vc_t        vc;
        logic       msg_v;
        logic       sum_v;
        res_t       msg_res;
        res_t       sum_res;

        s = state_reg;
        le = '0;
        vc = '0;
        msg_v = 1'b0;
        sum_v = 1'b0;
        msg_res = '0;
        sum_res = '0;
        msg_res.kind = KIND_MESSAGE;
        msg_res.msg_byte = in_byte;

        if (active(s.phase)) begin
            if ((in_byte == CH_CR) || (in_byte == CH_LF)) begin
                le = line_end(s);
                s = le.s;
                if (le.sum) begin
                    sum_v = 1'b1;
                    sum_res.outcome = 1'b0;
                end
            end else begin
                case (s.lp)
                    LP_START:
                    begin
                        if (in_byte == CH_COLON) begin
                            s.kmis = 1'b1;
                        end else begin
                            s.kmis = 1'b0;
                            s.kpos = 4'd0;
                            s.lp = LP_KEY;
                            s = key_char(s, in_byte);
                        end
                    end
                    LP_KEY:
                    begin
                        if (in_byte == CH_COLON) begin
                            s.kmis = !key_done(s);
                            s.lp = LP_SPACES;
                        end else begin
                            s = key_char(s, in_byte);
                        end
                    end
                    LP_SPACES:
                    begin
                        if (in_byte != CH_SPACE) begin
                            s.lp = LP_VALUE;
                            vc = value_char(s, in_byte);
                            s = vc.s;
                            msg_v = vc.msg;
                        end
                    end
                    default:
                    begin
                        vc = value_char(s, in_byte);
                        s = vc.s;
                        msg_v = vc.msg;
                    end
                endcase
            end
        end

        if (end_of_response) begin
            if (active(s.phase)) begin
                le = line_end(s);
                s = le.s;
                if (le.sum) begin
                    sum_v = 1'b1;
                    sum_res.outcome = 1'b0;
                end
            end
            if (s.phase != PH_DONE) begin
                sum_v = 1'b1;
                sum_res.outcome = 1'b1;
            end
        end

        sum_res.kind = KIND_SUMMARY;
        sum_res.req_ident = s.rid;
        sum_res.status_val = s.st;
        sum_res.truncated = s.trunc;
        sum_res.is_last = 1'b1;

        if (end_of_response) begin
            s = init_state();
        end

        push = '0;
        if (accept) begin
            state_next = s;
            if (msg_v) begin
                push.first = msg_res;
                push.second = sum_res;
                push.count = sum_v ? 2'd2 : 2'd1;
            end else begin
                push.first = sum_res;
                push.count = {1'b0, sum_v};
            end
        end else begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= init_state();
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/kvrp_out_fifo.sv @@
// Result queue of the response parser: takes up to two results per cycle and
// presents one per cycle at its head while pop is high. Depends on kvrp_pkg.
`timescale 1ns / 1ps

module kvrp_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  kvrp_pkg::push_t push,
    output logic            space_ok,
    output kvrp_pkg::res_t  head,
    output logic            head_valid,
    input  logic            pop
);
    import kvrp_pkg::*;

    res_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg;
    logic [FIFO_PTR_W:0]   count_next;
    logic                  pop_do;

    assign head_valid = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];
    assign space_ok = (count_reg <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2));
    assign pop_do = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = pop_do ? (rd_ptr_reg + FIFO_PTR_W'(1)) : rd_ptr_reg;
        count_next = count_reg + (FIFO_PTR_W + 1)'(push.count)
                     - (FIFO_PTR_W + 1)'(pop_do);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

endmodule

@@ design/key_value_response_parser_unit.sv @@
// Top level of the key/value response parser: stream ports, parser and result queue.
// Depends on kvrp_pkg, kvrp_parser and kvrp_out_fifo.
`timescale 1ns / 1ps
//
// The slave stream carries one response character per transfer; tlast marks the
// last character of a response, after which the parser starts over for the next.
// The master stream carries results: tuser 0 is a message byte of the value line,
// tuser 1 is the summary of a response, which also has tlast set.
// The parser checks the header, identifier, status and value lines in
// order, one character per cycle while the slave side is ready, and pushes
// zero, one or two results per character into a four-entry result queue.
// The results of an input transfer are registered into the queue when it is accepted.
// Throughput is one input transfer per cycle; the slave side is ready whenever
// the queue has room for two results, so the second result of a character
// waits in the queue until the receiver takes it.
// When the receiver stalls, results wait in the queue and input continues until
// the queue holds more than two results.
// Reset clears the parser to expect a header line and empties the queue.
//

module key_value_response_parser_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // in_byte
    input  logic                             s_axis_tlast,  // end_of_response
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // message_byte, identifier, status, outcome, truncated, zero fill
    output logic [kvrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                       m_axis_tuser,  // result_kind
    output logic                             m_axis_tlast   // last
);
    import kvrp_pkg::*;

    push_t push;
    res_t  head;
    logic  space_ok;
    logic  head_valid;
    logic  accept;

    assign s_axis_tready = space_ok;
    assign accept = s_axis_tvalid && space_ok;

    kvrp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .in_byte         (s_axis_tdata),
        .end_of_response (s_axis_tlast),
        .push            (push)
    );

    kvrp_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head       (head),
        .head_valid (head_valid),
        .pop        (m_axis_tready)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), head.truncated, head.outcome,
                           head.status_val, head.req_ident, head.msg_byte};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.is_last;

endmodule
